/* rtl/telnet_option_negotiator_top_assert.svh */
// Assertion macros for the telnet negotiator checker.
`ifndef TELNET_OPTION_NEGOTIATOR_TOP_ASSERT_SVH
`define TELNET_OPTION_NEGOTIATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TON_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TON_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ton_pkg.sv */
// Package: telnet byte codes, parser stage type and shared structs.
package ton_pkg;

  localparam logic [7:0] B_IAC    = 8'd255;
  localparam logic [7:0] B_DONT   = 8'd254;
  localparam logic [7:0] B_DO     = 8'd253;
  localparam logic [7:0] B_WONT   = 8'd252;
  localparam logic [7:0] B_WILL   = 8'd251;
  localparam logic [7:0] B_SB     = 8'd250;
  localparam logic [7:0] B_SE     = 8'd240;
  localparam logic [7:0] B_CMD_LO = 8'd236;
  localparam logic [7:0] B_CMD_HI = 8'd249;
  localparam logic [7:0] O_BINARY = 8'd0;
  localparam logic [7:0] O_ECHO   = 8'd1;
  localparam logic [7:0] O_SGA    = 8'd3;
  localparam logic [7:0] O_TTYPE  = 8'd24;
  localparam logic [7:0] O_NAWS   = 8'd31;
  localparam logic [7:0] Q_SEND   = 8'd1;

  localparam int OUT_W = 32;

  typedef enum logic [2:0] {
    ST_HUNT    = 3'd0,
    ST_CMD     = 3'd1,
    ST_OPT     = 3'd2,
    ST_SEND_Q  = 3'd3,
    ST_WAIT_SE = 3'd4
  } stage_t;

  // Negotiation state carried from byte to byte.
  typedef struct packed {
    stage_t     stage;
    logic [7:0] pending;
    logic       binary;
    logic       sga_done;
    logic       echo_done;
    logic       will_bin_done;
  } neg_state_t;

  // One result, packed lowest field in the lowest bits.
  typedef struct packed {
    logic [2:0] pad;
    logic       binary_active;
    logic       send_terminal_type;
    logic       send_window_size;
    logic [7:0] reply_opt;
    logic [7:0] reply_cmd;
    logic       reply_valid;
    logic [7:0] data_byte;
    logic       data_valid;
  } result_t;

endpackage

/* rtl/ton_decode.sv */
// Per-byte IAC parser: next state and result from current state and byte.
module ton_decode (
  input  logic [7:0]          rx_byte,
  input  ton_pkg::neg_state_t st,
  output ton_pkg::neg_state_t st_nxt,
  output ton_pkg::result_t    res
);

  always_comb begin
    st_nxt = st;
    res    = '0;
    case (st.stage)
      ton_pkg::ST_CMD: begin
        if (rx_byte == ton_pkg::B_IAC ||
            (rx_byte >= ton_pkg::B_CMD_LO && rx_byte <= ton_pkg::B_CMD_HI)) begin
          st_nxt.stage = ton_pkg::ST_HUNT;
        end else begin
          st_nxt.pending = rx_byte;
          st_nxt.stage   = ton_pkg::ST_OPT;
        end
      end
      ton_pkg::ST_OPT: begin
        st_nxt.stage = ton_pkg::ST_HUNT;
        if (st.pending == ton_pkg::B_DONT) begin
          if (rx_byte == ton_pkg::B_IAC) begin
            st_nxt.stage = ton_pkg::ST_CMD;
          end else begin
            res.reply_valid = 1'b1;
            res.reply_cmd   = ton_pkg::B_WONT;
            res.reply_opt   = rx_byte;
          end
        end else if (st.pending == ton_pkg::B_DO) begin
          res.reply_valid = 1'b1;
          res.reply_opt   = rx_byte;
          res.reply_cmd   = ton_pkg::B_WILL;
          if (rx_byte == ton_pkg::O_BINARY) begin
            st_nxt.binary = 1'b1;
          end else if (rx_byte == ton_pkg::O_SGA) begin
            st_nxt.sga_done = 1'b1;
          end else if (rx_byte == ton_pkg::O_NAWS) begin
            res.send_window_size = 1'b1;
          end else if (rx_byte != ton_pkg::O_TTYPE) begin
            res.reply_cmd = ton_pkg::B_WONT;
          end
        end else if (st.pending == ton_pkg::B_WILL) begin
          if (rx_byte == ton_pkg::O_ECHO) begin
            if (!st.echo_done) begin
              res.reply_valid  = 1'b1;
              res.reply_cmd    = ton_pkg::B_DO;
              res.reply_opt    = rx_byte;
              st_nxt.echo_done = 1'b1;
            end
          end else if (rx_byte == ton_pkg::O_BINARY) begin
            if (!st.will_bin_done) begin
              res.reply_valid      = 1'b1;
              res.reply_cmd        = ton_pkg::B_DO;
              res.reply_opt        = rx_byte;
              st_nxt.will_bin_done = 1'b1;
            end
          end else if (rx_byte == ton_pkg::O_SGA) begin
            if (!st.sga_done) begin
              res.reply_valid = 1'b1;
              res.reply_cmd   = ton_pkg::B_DO;
              res.reply_opt   = rx_byte;
              st_nxt.sga_done = 1'b1;
            end
          end else begin
            res.reply_valid = 1'b1;
            res.reply_cmd   = ton_pkg::B_DONT;
            res.reply_opt   = rx_byte;
          end
        end else if (st.pending == ton_pkg::B_WONT) begin
          res.reply_valid = 1'b1;
          res.reply_cmd   = ton_pkg::B_DONT;
          res.reply_opt   = rx_byte;
        end else if (st.pending == ton_pkg::B_SB) begin
          if (rx_byte == ton_pkg::O_TTYPE) begin
            st_nxt.stage = ton_pkg::ST_SEND_Q;
          end
        end
      end
      ton_pkg::ST_SEND_Q: begin
        st_nxt.stage = (rx_byte == ton_pkg::Q_SEND) ? ton_pkg::ST_WAIT_SE : ton_pkg::ST_HUNT;
      end
      ton_pkg::ST_WAIT_SE: begin
        if (rx_byte == ton_pkg::B_SE) begin
          res.send_terminal_type = 1'b1;
          st_nxt.stage           = ton_pkg::ST_HUNT;
        end
      end
      default: begin
        // hunting; stray stage codes behave the same
        if (rx_byte != ton_pkg::B_IAC) begin
          res.data_valid = 1'b1;
          res.data_byte  = rx_byte;
        end else begin
          st_nxt.stage = ton_pkg::ST_CMD;
        end
      end
    endcase
    res.binary_active = st_nxt.binary;
  end

endmodule

/* rtl/telnet_option_negotiator_top.sv */
// Top level: telnet option negotiator, one received byte in, one result out.
//
//  channel | dir | ports                          | payload
//  --------+-----+--------------------------------+-------------------------------
//  in      | in  | in_tvalid in_tready in_tdata   | [7:0] rx_byte
//  out     | out | out_tvalid out_tready out_tdata| see out_tdata port comment
//
// One byte per clock sustained while out_tready is high; out_tvalid rises once an
// accepted byte has passed the input register, the single parse step and the
// result register; the state update is committed when a byte moves on.
// rst_n (synchronous, active low) clears both valid flags and all parser state.
// With out_tready low the result holds, and one more request can still be
// taken into the input register before in_tready drops.
module telnet_option_negotiator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] data_valid, [8:1] data_byte, [9] reply_valid, [17:10] reply_cmd,
  // [25:18] reply_opt, [26] send_window_size, [27] send_terminal_type,
  // [28] binary_active, [31:29] zero
  output logic [ton_pkg::OUT_W-1:0] out_tdata
);

  // input register
  logic       a_valid_r, a_valid_nxt;
  logic [7:0] a_byte_r;
  // parser state
  ton_pkg::neg_state_t st_r, st_nxt, st_dec;
  // result register
  logic              out_valid_r, out_valid_nxt;
  ton_pkg::result_t  out_data_r, res_dec;

  logic a_move;   // input register hands its byte to the result register
  logic in_take;

  assign a_move  = a_valid_r && (!out_valid_r || out_tready);
  assign in_take = in_tvalid && in_tready;
  assign in_tready = !a_valid_r || a_move;

  ton_decode u_decode (
    .rx_byte (a_byte_r),
    .st      (st_r),
    .st_nxt  (st_dec),
    .res     (res_dec)
  );

  always_comb begin
    a_valid_nxt   = in_take ? 1'b1 : (a_move ? 1'b0 : a_valid_r);
    out_valid_nxt = a_move ? 1'b1 : ((out_valid_r && out_tready) ? 1'b0 : out_valid_r);
    st_nxt        = a_move ? st_dec : st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '{stage: ton_pkg::ST_HUNT, pending: 8'd0, binary: 1'b0,
                       sga_done: 1'b0, echo_done: 1'b0, will_bin_done: 1'b0};
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      a_byte_r <= in_tdata;
    end
    if (a_move) begin
      out_data_r <= res_dec;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* rtl/ton_checker.sv */
// Port-level checker for the telnet negotiator, bound to the top level.
`include "telnet_option_negotiator_top_assert.svh"

module ton_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [ton_pkg::OUT_W-1:0] out_tdata
);

  logic       stalled;
  logic       lone_take;
  logic       data_on;
  logic       no_reply;
  logic       reply_on;
  logic       reply_cmd_ok;
  logic [7:0] reply_cmd;

  assign stalled   = out_tvalid && !out_tready;
  assign lone_take = in_tvalid && in_tready && !out_tvalid;
  assign data_on   = out_tvalid && out_tdata[0];
  assign no_reply  = out_tvalid && !out_tdata[9];
  assign reply_on  = out_tvalid && out_tdata[9];
  assign reply_cmd = out_tdata[17:10];
  assign reply_cmd_ok = reply_cmd == ton_pkg::B_WILL || reply_cmd == ton_pkg::B_WONT ||
                        reply_cmd == ton_pkg::B_DO   || reply_cmd == ton_pkg::B_DONT;

  `TON_ASSERT_NEXT(a_out_hold, stalled, out_tvalid && $stable(out_tdata), "result moved in stall")
  `TON_ASSERT_SAME(a_one_kind, data_on, !out_tdata[9], "payload and reply together")
  `TON_ASSERT_SAME(a_reply_zero, no_reply, out_tdata[25:10] == 16'd0, "stray reply fields")
  `TON_ASSERT_SAME(a_reply_cmd, reply_on, reply_cmd_ok, "reply command out of range")
  `TON_ASSERT_NEXT(a_in_to_out, lone_take, in_tready || out_tvalid, "input stuck, no result")

endmodule

bind telnet_option_negotiator_top ton_checker u_ton_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
